// ===== src/vwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// vwsd_pkg
// Shared types and constants of the adaptive-window step-rate estimator.
// ----------------------------------------------------------------------------
package vwsd_pkg;

    localparam int MAX_WINDOW_DEF = 63;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CNT_W     = 32;
    localparam int RATE_W    = 48;
    localparam int WIN_W     = 6;
    localparam int STEP_W    = 16;
    localparam int DVS_W     = STEP_W + 1;
    localparam int NUM_W     = WIN_W + STEP_W;
    localparam int WIN_Q_BITS = 6;

    localparam logic [RATE_W-1:0] RATE_POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [RATE_W-1:0] RATE_NEG_LIM = 48'h8000_0000_0000;

    localparam logic REG_WINDOW_MAX = 1'b0;
    localparam logic REG_MAX_STEP   = 1'b1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic signed [31:0] step_count;
    } t_in;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate;
        logic [WIN_W-1:0]         window_used;
    } t_out;

    typedef struct packed {
        logic acc;
        logic diff;
        logic absv;
        logic win;
        logic ld1;
        logic w1;
        logic rdw;
        logic subw;
        logic ld2;
        logic step;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic trivial;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/vwsd_div.sv =====
// ----------------------------------------------------------------------------
// vwsd_div
// Bit-serial restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module vwsd_div #(
    parameter int QW = 48
) (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic                       i_step,
    input  logic [vwsd_pkg::DVS_W-1:0] i_rem_init,
    input  logic [QW-1:0]              i_quo_init,
    input  logic [vwsd_pkg::DVS_W-1:0] i_dvs,
    output logic [QW-1:0]              o_quo
);

    logic [vwsd_pkg::DVS_W-1:0] r_rem, n_rem;
    logic [QW-1:0]              r_quo, n_quo;
    logic [vwsd_pkg::DVS_W-1:0] r_dvs;
    logic [vwsd_pkg::DVS_W:0]   sh;
    logic                       ge;

    always_comb begin
        sh    = {r_rem, r_quo[QW-1]};
        ge    = (sh >= {1'b0, r_dvs});
        n_rem = ge ? vwsd_pkg::DVS_W'(sh - {1'b0, r_dvs}) : sh[vwsd_pkg::DVS_W-1:0];
        n_quo = {r_quo[QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_rem_init;
            r_quo <= i_quo_init;
            r_dvs <= i_dvs;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

// ===== src/vwsd_dp.sv =====
// ----------------------------------------------------------------------------
// vwsd_dp
// Datapath: count ring, window choice, shared divider and result register.
// ----------------------------------------------------------------------------
module vwsd_dp #(
    parameter int MAX_WINDOW = vwsd_pkg::MAX_WINDOW_DEF,
    parameter int FRAC_BITS  = vwsd_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vwsd_pkg::t_dp_cmd           i_cmd,
    output vwsd_pkg::t_dp_sts           o_sts,
    input  vwsd_pkg::t_in               i_data,
    input  logic [vwsd_pkg::WIN_W-1:0]  i_window_max,
    input  logic [vwsd_pkg::STEP_W-1:0] i_max_step,
    output logic                        o_valid,
    input  logic                        i_stall,
    output vwsd_pkg::t_out              o_data
);

    localparam int DEPTH = MAX_WINDOW + 1;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW    = ((IW > vwsd_pkg::WIN_W) ? IW : vwsd_pkg::WIN_W) + 1;
    localparam int QW    = vwsd_pkg::CNT_W + FRAC_BITS;
    localparam int CW    = (QW > vwsd_pkg::RATE_W) ? QW : vwsd_pkg::RATE_W;
    localparam int DW1   = vwsd_pkg::NUM_W + 1;

    logic [vwsd_pkg::CNT_W-1:0] mem [DEPTH];
    logic [vwsd_pkg::CNT_W-1:0] r_rd;
    logic                       r_rd_vld;
    logic [DEPTH-1:0]           r_vld;
    logic [vwsd_pkg::CNT_W-1:0] r_fill;
    logic [IW-1:0]              r_head, n_head;
    logic [vwsd_pkg::CNT_W-1:0] r_x;
    logic                       r_cmd;
    logic [vwsd_pkg::CNT_W-1:0] r_d;
    logic                       r_neg;
    logic [vwsd_pkg::WIN_W-1:0] r_w;
    logic [vwsd_pkg::NUM_W-1:0] r_num;
    logic                       r_out_valid;
    vwsd_pkg::t_out             r_out;

    logic [vwsd_pkg::CNT_W-1:0] prev;
    logic [vwsd_pkg::WIN_W-1:0] weff;
    logic                       small_w;
    logic                       big_d;
    logic [AW-1:0]              hw, ww, idx_a;
    logic [IW-1:0]              idx_w, rd_addr;
    logic [DW1-1:0]             dvd1;
    logic [vwsd_pkg::CNT_W-1:0] mag;
    logic [vwsd_pkg::DVS_W-1:0] rem_init, dvs;
    logic [QW-1:0]              quo_init, quo;
    logic [CW-1:0]              qx;
    logic [vwsd_pkg::RATE_W-1:0] qs;

    always_comb begin
        prev    = r_rd_vld ? r_rd : r_fill;
        n_head  = (r_head == IW'(MAX_WINDOW)) ? '0 : IW'(r_head + 1'b1);
        weff    = (int'(i_window_max) > MAX_WINDOW) ? vwsd_pkg::WIN_W'(MAX_WINDOW)
                                                     : i_window_max;
        small_w = (weff <= vwsd_pkg::WIN_W'(1));
        big_d   = (r_d >= {16'd0, i_max_step});
        hw      = AW'(r_head);
        ww      = AW'(r_w);
        idx_a   = (hw >= ww) ? AW'(hw - ww) : AW'(hw + AW'(DEPTH) - ww);
        idx_w   = idx_a[IW-1:0];
        rd_addr = i_cmd.acc ? r_head : idx_w;
        dvd1    = DW1'({r_num, 1'b0}) + DW1'(i_max_step);
        mag     = r_d[vwsd_pkg::CNT_W-1] ? (~r_d + 1'b1) : r_d;
        if (i_cmd.ld1) begin
            rem_init = dvd1[DW1-1:vwsd_pkg::WIN_Q_BITS];
            quo_init = {dvd1[vwsd_pkg::WIN_Q_BITS-1:0], {(QW-vwsd_pkg::WIN_Q_BITS){1'b0}}};
            dvs      = {i_max_step, 1'b0};
        end else begin
            rem_init = '0;
            quo_init = QW'({mag, {FRAC_BITS{1'b0}}});
            dvs      = vwsd_pkg::DVS_W'(r_w);
        end
        qx = CW'(quo);
        if (r_neg) begin
            qs = (qx > CW'(vwsd_pkg::RATE_NEG_LIM)) ? vwsd_pkg::RATE_NEG_LIM
                                                    : qx[vwsd_pkg::RATE_W-1:0];
            qs = ~qs + 1'b1;
        end else begin
            qs = (qx > CW'(vwsd_pkg::RATE_POS_LIM)) ? vwsd_pkg::RATE_POS_LIM
                                                    : qx[vwsd_pkg::RATE_W-1:0];
        end
    end

    assign o_sts.trivial  = small_w || big_d || (r_d == '0);
    assign o_sts.out_free = !r_out_valid || !i_stall;

    vwsd_div #(
        .QW (QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.ld1 || i_cmd.ld2),
        .i_step     (i_cmd.step),
        .i_rem_init (rem_init),
        .i_quo_init (quo_init),
        .i_dvs      (dvs),
        .o_quo      (quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && i_data.cmd == vwsd_pkg::CMD_SAMPLE) begin
            mem[n_head] <= i_data.step_count;
        end
        if (i_cmd.acc || i_cmd.rdw) begin
            r_rd     <= mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_fill      <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                if (i_data.cmd == vwsd_pkg::CMD_FILL) begin
                    r_vld  <= '0;
                    r_fill <= i_data.step_count;
                end else begin
                    r_head         <= n_head;
                    r_vld[n_head]  <= 1'b1;
                end
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_x   <= i_data.step_count;
            r_cmd <= i_data.cmd;
        end
        if (i_cmd.diff || i_cmd.subw) begin
            r_d <= r_x - prev;
        end
        if (i_cmd.absv) begin
            r_d <= mag;
        end
        if (i_cmd.win) begin
            if (small_w || big_d) begin
                r_w <= vwsd_pkg::WIN_W'(1);
            end else if (r_d == '0) begin
                r_w <= weff;
            end
            r_num <= vwsd_pkg::NUM_W'((weff - 1'b1) * (i_max_step - r_d[vwsd_pkg::STEP_W-1:0]));
        end
        if (i_cmd.w1) begin
            r_w <= vwsd_pkg::WIN_W'(quo[vwsd_pkg::WIN_Q_BITS-1:0] + 1'b1);
        end
        if (i_cmd.ld2) begin
            r_neg <= r_d[vwsd_pkg::CNT_W-1];
        end
        if (i_cmd.fin) begin
            if (r_cmd == vwsd_pkg::CMD_FILL) begin
                r_out.rate        <= '0;
                r_out.window_used <= vwsd_pkg::WIN_W'(1);
            end else begin
                r_out.rate        <= qs;
                r_out.window_used <= r_w;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> o_valid)
        else $error("result load did not raise valid");

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result dropped");

endmodule

// ===== src/vwsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// vwsd_ctrl
// Sequencer: steps one request through window choice and the divisions it needs.
// ----------------------------------------------------------------------------
module vwsd_ctrl #(
    parameter int FRAC_BITS = vwsd_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_req_cmd,
    output logic              o_stall,
    input  vwsd_pkg::t_dp_sts i_sts,
    output vwsd_pkg::t_dp_cmd o_cmd
);

    localparam int QW = vwsd_pkg::CNT_W + FRAC_BITS;
    localparam int CW = $clog2(QW);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIFF = 4'd1;
    localparam logic [3:0] S_ABS  = 4'd2;
    localparam logic [3:0] S_WIN  = 4'd3;
    localparam logic [3:0] S_LD1  = 4'd4;
    localparam logic [3:0] S_DIV1 = 4'd5;
    localparam logic [3:0] S_W1   = 4'd6;
    localparam logic [3:0] S_RDW  = 4'd7;
    localparam logic [3:0] S_SUBW = 4'd8;
    localparam logic [3:0] S_LD2  = 4'd9;
    localparam logic [3:0] S_DIV2 = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          acc;

    assign acc     = (r_state == S_IDLE) && i_valid;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.acc = 1'b1;
                    n_state   = (i_req_cmd == vwsd_pkg::CMD_FILL) ? S_FIN : S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_ABS;
            end
            S_ABS: begin
                o_cmd.absv = 1'b1;
                n_state    = S_WIN;
            end
            S_WIN: begin
                o_cmd.win = 1'b1;
                n_state   = i_sts.trivial ? S_RDW : S_LD1;
            end
            S_LD1: begin
                o_cmd.ld1 = 1'b1;
                n_cnt     = CW'(vwsd_pkg::WIN_Q_BITS - 1);
                n_state   = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_W1;
                end
            end
            S_W1: begin
                o_cmd.w1 = 1'b1;
                n_state  = S_RDW;
            end
            S_RDW: begin
                o_cmd.rdw = 1'b1;
                n_state   = S_SUBW;
            end
            S_SUBW: begin
                o_cmd.subw = 1'b1;
                n_state    = S_LD2;
            end
            S_LD2: begin
                o_cmd.ld2 = 1'b1;
                n_cnt     = CW'(QW - 1);
                n_state   = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_state == S_DIFF || r_state == S_FIN))
        else $error("accepted request did not start");

    a_div1_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1) |-> (r_cnt <= CW'(vwsd_pkg::WIN_Q_BITS - 1)))
        else $error("window division count out of range");

    a_fin_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_sts.out_free) |=> (r_state == S_FIN))
        else $error("result left while output was full");

endmodule

// ===== src/variable_window_step_difference_top.sv =====
// ----------------------------------------------------------------------------
// variable_window_step_difference_top
// Adaptive-window step-rate estimator for a Hall-sensor step counter.
// Each sample request yields one result: the count difference over a window
// picked from the latest step size, divided by the window, in signed fixed
// point with FRAC_BITS fraction bits. A fill request loads the whole history
// with its count and returns rate 0, window 1. A new request is accepted only
// once the previous result is loaded, which waits while the output stalls.
// The bit-serial divider takes 6 steps for the window choice, skipped when
// the window needs no division, and 32 + FRAC_BITS for the rate; a fill
// needs neither. The history is a MAX_WINDOW+1 deep memory whose entries
// read as the last fill value until written, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module variable_window_step_difference_top #(
    parameter int MAX_WINDOW = vwsd_pkg::MAX_WINDOW_DEF,
    parameter int FRAC_BITS  = vwsd_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  vwsd_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output vwsd_pkg::t_out o_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [vwsd_pkg::WIN_W-1:0]  r_window_max;
    logic [vwsd_pkg::STEP_W-1:0] r_max_step;
    logic                        wr_en;
    vwsd_pkg::t_dp_cmd           dp_cmd;
    vwsd_pkg::t_dp_sts           dp_sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_max <= '0;
            r_max_step   <= vwsd_pkg::STEP_W'(1);
        end else if (wr_en) begin
            unique case (paddr[2])
                vwsd_pkg::REG_WINDOW_MAX: r_window_max <= pwdata[vwsd_pkg::WIN_W-1:0];
                vwsd_pkg::REG_MAX_STEP:   r_max_step   <= pwdata[vwsd_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            vwsd_pkg::REG_WINDOW_MAX: prdata = 32'(r_window_max);
            vwsd_pkg::REG_MAX_STEP:   prdata = 32'(r_max_step);
            default:                  prdata = '0;
        endcase
    end

    vwsd_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_req_cmd (i_data.cmd),
        .o_stall   (o_stall),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    vwsd_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_data       (i_data),
        .i_window_max (r_window_max),
        .i_max_step   (r_max_step),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

endmodule

// ===== tb/vwsd_rate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwsd_rate_checker
// Watches the request, result and register ports of the step-rate estimator.
// Keeps its own copy of the count history and registers, works out the rate
// and window of every accepted request, and compares each accepted result
// field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module vwsd_rate_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_stall,
    input  vwsd_pkg::t_in  i_req,
    input  logic           i_res_valid,
    input  logic           i_res_stall,
    input  vwsd_pkg::t_out i_res,
    input  logic           i_psel,
    input  logic           i_penable,
    input  logic           i_pwrite,
    input  logic [2:0]     i_paddr,
    input  logic [31:0]    i_pwdata,
    input  logic           i_pready,
    output int             o_pending,
    output int             o_mismatches
);
    import vwsd_pkg::*;

    localparam int DEPTH = MAX_WINDOW_DEF + 1;

    logic [CNT_W-1:0]  count_ring [0:DEPTH-1];
    int                ring_head;
    logic [WIN_W-1:0]  win_max_q;
    logic [STEP_W-1:0] max_step_q;
    t_out              rate_expected [$];
    int                mismatch_cnt;

    function automatic logic [WIN_W-1:0] pick_window(input logic [CNT_W-1:0] d);
        int          wm;
        logic [63:0] m;
        logic [63:0] num;
        logic [63:0] q;
        wm = win_max_q;
        if (wm > MAX_WINDOW_DEF) wm = MAX_WINDOW_DEF;
        if (wm <= 1) return WIN_W'(1);
        if (d >= max_step_q) return WIN_W'(1);
        if (d == '0) return WIN_W'(wm);
        m   = 64'(max_step_q);
        num = 64'(wm - 1) * (m - 64'(d));
        q   = (2 * num + m) / (2 * m);
        return WIN_W'(64'd1 + q);
    endfunction

    task automatic predict_rate(input t_in req, output t_out res);
        logic [CNT_W-1:0] x;
        logic [CNT_W-1:0] diff1;
        logic [CNT_W-1:0] d;
        logic [CNT_W-1:0] diffw;
        logic [CNT_W-1:0] mag;
        logic [63:0]      q;
        logic [WIN_W-1:0] w;
        int               i;
        x = req.step_count;
        if (req.cmd == CMD_FILL) begin
            for (i = 0; i < DEPTH; i++) count_ring[i] = x;
            res.rate        = '0;
            res.window_used = WIN_W'(1);
        end else begin
            ring_head = (ring_head + 1) % DEPTH;
            count_ring[ring_head] = x;
            diff1 = x - count_ring[(ring_head + DEPTH - 1) % DEPTH];
            d     = diff1[CNT_W-1] ? (32'd0 - diff1) : diff1;
            w     = pick_window(d);
            diffw = x - count_ring[(ring_head + DEPTH - int'(w)) % DEPTH];
            mag   = diffw[CNT_W-1] ? (32'd0 - diffw) : diffw;
            q     = (64'(mag) << FRAC_BITS_DEF) / 64'(w);
            if (diffw[CNT_W-1]) begin
                if (q > 64'(RATE_NEG_LIM)) q = 64'(RATE_NEG_LIM);
                res.rate = RATE_W'(64'd0 - q);
            end else begin
                if (q > 64'(RATE_POS_LIM)) q = 64'(RATE_POS_LIM);
                res.rate = RATE_W'(q);
            end
            res.window_used = w;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        int   i;
        if (!i_rst_n) begin
            for (i = 0; i < DEPTH; i++) count_ring[i] = '0;
            ring_head    = 0;
            win_max_q    = '0;
            max_step_q   = STEP_W'(1);
            mismatch_cnt = 0;
            rate_expected.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_WINDOW_MAX) win_max_q = i_pwdata[WIN_W-1:0];
                else max_step_q = i_pwdata[STEP_W-1:0];
            end
            if (i_req_valid && !i_req_stall) begin
                predict_rate(i_req, want);
                rate_expected.push_back(want);
            end
            if (i_res_valid && !i_res_stall) begin
                if (rate_expected.size() == 0) begin
                    $display("%0t: result without request, got rate %0d window %0d",
                             $time, i_res.rate, i_res.window_used);
                    mismatch_cnt++;
                end else begin
                    want = rate_expected.pop_front();
                    if (want.rate !== i_res.rate) begin
                        $display("%0t: rate expected %0d, got %0d",
                                 $time, want.rate, i_res.rate);
                        mismatch_cnt++;
                    end
                    if (want.window_used !== i_res.window_used) begin
                        $display("%0t: window_used expected %0d, got %0d",
                                 $time, want.window_used, i_res.window_used);
                        mismatch_cnt++;
                    end
                end
            end
        end
        o_pending    <= rate_expected.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the adaptive-window step-rate estimator: a directed run over
// the field extremes, fill requests and window corner cases, then phases of
// random count streams under several register settings and idle patterns.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import vwsd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES  = 8;
    localparam int DRAIN_TAIL  = 120;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_data  = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int          pending;
    int          mismatches;
    int          cycles        = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic [31:0] cur_count     = '0;
    logic [15:0] step_cfg      = 16'd1;

    variable_window_step_difference_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    vwsd_rate_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req        (i_data),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res        (o_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_req(input logic cmd, input logic [31:0] value);
        t_in req;
        req.cmd        = cmd;
        req.step_count = value;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_MAX_STEP) step_cfg = value[15:0];
    endtask

    task automatic configure(input logic [31:0] win_max, input logic [31:0] max_step);
        wait_drained();
        write_reg(REG_WINDOW_MAX, win_max);
        write_reg(REG_MAX_STEP, max_step);
    endtask

    task automatic next_request(output logic cmd, output logic [31:0] value);
        int roll;
        int span;
        int delta;
        roll = $urandom_range(0, 99);
        span = int'(step_cfg) + 1;
        cmd  = CMD_SAMPLE;
        if (roll < 8) begin
            cmd       = CMD_FILL;
            cur_count = $urandom();
        end else if (roll < 20) begin
            delta = 0;
        end else if (roll < 70) begin
            delta     = int'($urandom_range(0, 2 * span)) - span;
            cur_count = cur_count + delta;
        end else if (roll < 85) begin
            delta     = int'($urandom_range(0, 4194304)) - 2097152;
            cur_count = cur_count + delta;
        end else if (roll < 95) begin
            cur_count = $urandom();
        end else begin
            cur_count = ($urandom_range(0, 1) ? 32'h7FFF_FFF8 : 32'h8000_0000)
                        + $urandom_range(0, 15);
        end
        value = cur_count;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1: begin
                send_idle_pct = 83;
                stall_pct     = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct     = 83;
            end
            default: begin
                send_idle_pct = 24;
                stall_pct     = 24;
            end
        endcase
    endtask

    initial begin
        logic [31:0] wm;
        logic [31:0] ms;
        logic        cmd;
        logic [31:0] value;
        int          p;
        int          n;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: raw difference, history still zero
        send_req(CMD_SAMPLE, 32'd0);
        send_req(CMD_SAMPLE, 32'd5);
        send_req(CMD_SAMPLE, 32'hFFFF_FFF9);
        send_req(CMD_SAMPLE, 32'h7FFF_FFFF);
        send_req(CMD_SAMPLE, 32'h8000_0000);
        send_req(CMD_FILL, 32'd100);

        // zero max_step forces the one-step window
        configure(32'd63, 32'd0);
        send_req(CMD_SAMPLE, 32'd100);
        send_req(CMD_SAMPLE, 32'd105);

        // all-ones writes: high bits dropped, both registers at their maximum
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(CMD_SAMPLE, 32'd105);
        send_req(CMD_SAMPLE, 32'd106);
        send_req(CMD_SAMPLE, 32'd106 + 32'd65535);
        send_req(CMD_SAMPLE, 32'd106 + 32'd65535 + 32'd65534);
        send_req(CMD_FILL, 32'h8000_0000);
        send_req(CMD_SAMPLE, 32'h7FFF_FFFF);
        send_req(CMD_SAMPLE, 32'h7FFF_FFFF);

        configure(32'd1, 32'd1000);
        send_req(CMD_SAMPLE, 32'h1234_5678);

        // rounding of the window between the extremes
        configure(32'd10, 32'd8);
        send_req(CMD_FILL, 32'd0);
        send_req(CMD_SAMPLE, 32'd4);
        send_req(CMD_SAMPLE, 32'd8);
        send_req(CMD_SAMPLE, 32'd7);

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    wm = 32'd0;
                    ms = 32'd65535;
                end
                1: begin
                    wm = 32'd63;
                    ms = 32'd65535;
                end
                2: begin
                    wm = 32'd63;
                    ms = 32'd1;
                end
                3: begin
                    wm = 32'd1;
                    ms = 32'd100;
                end
                4: begin
                    wm = 32'd63;
                    ms = 32'd0;
                end
                5: begin
                    wm = $urandom_range(0, 63);
                    ms = $urandom_range(0, 65535);
                end
                6: begin
                    wm = $urandom_range(2, 63);
                    ms = $urandom_range(1, 300);
                end
                default: begin
                    wm = $urandom_range(2, 63);
                    ms = $urandom_range(0, 65535);
                end
            endcase
            configure(wm, ms);
            set_idle(p % 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                next_request(cmd, value);
                send_req(cmd, value);
            end
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
